FILE: hdl/altpid_pkg.sv
// ----------------------------------------------------------------------------
// altpid_pkg
// Types and constants that the altitude-hold PID files share.
// ----------------------------------------------------------------------------
package altpid_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_HOVER     = 3'd0;
  localparam logic [2:0] CFG_KP        = 3'd1;
  localparam logic [2:0] CFG_KI        = 3'd2;
  localparam logic [2:0] CFG_KD        = 3'd3;
  localparam logic [2:0] CFG_ERR_LIMIT = 3'd4;
  localparam logic [2:0] CFG_RATE_LIM  = 3'd5;

  // Height source codes (code 3 behaves as barometer)
  localparam logic [1:0] SRC_BARO  = 2'd0;
  localparam logic [1:0] SRC_FLOW  = 2'd1;
  localparam logic [1:0] SRC_LIDAR = 2'd2;

  // Fixed constants, Q24.8 where a distance or rate
  localparam logic signed [12:0] STICK_CENTRE = 13'sd1000;
  localparam logic signed [12:0] STICK_BAND   = 13'sd10;
  localparam logic signed [12:0] HOVER_OFFSET = 13'sd988;
  localparam logic [31:0]        ITERM_BAND   = 32'd51200;
  localparam logic [31:0]        KINK_RATE    = 32'd128000;
  localparam logic signed [33:0] KINK_OFFSET  = 34'sd256000;

  // Divide by ten on a 12-bit partial remainder: q = (x * RECIP) >> SHIFT
  localparam logic [12:0] DIV10_RECIP = 13'd6554;
  localparam int          DIV10_SHIFT = 16;
  localparam logic [11:0] DIV10       = 12'd10;
  localparam int          DIV_STEPS   = 7;   // bytes in a 56-bit magnitude

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [11:0]        stick_throttle;
    logic               range_good;
    logic [1:0]         height_source;
    logic signed [31:0] range_altitude;
    logic signed [31:0] range_rate;
    logic signed [31:0] baro_altitude;
    logic signed [31:0] climb_rate;
  } altpid_in_t;

  typedef struct packed {
    logic signed [31:0] throttle_command;
    logic signed [31:0] setpoint_out;
    logic signed [31:0] error_out;
  } altpid_out_t;

  typedef struct packed {
    logic [11:0] hover_throttle;
    logic [23:0] kp_gain;
    logic [23:0] ki_per_tick;
    logic [23:0] kd_gain;
    logic [30:0] error_limit;
    logic [30:0] rate_limit;
  } altpid_cfg_t;

  // One classified tick, front to back
  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] err;
    logic signed [33:0] vel;      // climb rate after the kink
    logic               relax;    // |err| at or above the integral band
  } altpid_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_DIV,
    S_INT,
    S_MUL_D,
    S_SUM
  } altpid_state_t;

endpackage

FILE: hdl/altpid_fifo.sv
// ----------------------------------------------------------------------------
// altpid_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module altpid_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  altpid_pkg::altpid_item_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output altpid_pkg::altpid_item_t rd_data,
  output logic                 empty
);
  import altpid_pkg::*;

  altpid_item_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]       wptr_r, rptr_r;
  logic [Q_CW-1:0]       count_r;
  logic                  do_wr, do_rd;

  assign full    = (count_r == Q_CW'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wptr_r <= bump(wptr_r);
      if (do_rd) rptr_r <= bump(rptr_r);
      if (do_wr && !do_rd) count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

endmodule

FILE: hdl/altpid_front.sv
// ----------------------------------------------------------------------------
// altpid_front
// Takes a tick, updates setpoint and last error, classifies for the back.
// ----------------------------------------------------------------------------
module altpid_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  altpid_pkg::altpid_in_t   in_data,
  input  altpid_pkg::altpid_cfg_t  cfg,
  input  logic                     q_full,
  output logic                     q_wr,
  output altpid_pkg::altpid_item_t q_data
);
  import altpid_pkg::*;

  logic signed [31:0] target_r, target_nxt;
  logic signed [31:0] last_err_r;
  logic signed [12:0] stick_dev;
  logic               refresh, jump;
  logic signed [31:0] fresh, tgt_now, alt_sel, err;
  logic signed [32:0] diff;
  logic [31:0]        err_mag, rate_mag, climb_mag;
  logic signed [33:0] c34, vel;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    return e[32] ? 32'(-e) : 32'(e);
  endfunction

  assign q_wr = in_push && !q_full;

  always_comb begin
    stick_dev = $signed({1'b0, in_data.stick_throttle}) - STICK_CENTRE;
    refresh   = (stick_dev > STICK_BAND) || (stick_dev < -STICK_BAND);
    fresh     = in_data.range_good ? in_data.range_altitude : in_data.baro_altitude;
    tgt_now   = refresh ? fresh : target_r;

    alt_sel = (in_data.height_source == SRC_FLOW) ? in_data.range_altitude
                                                  : in_data.baro_altitude;
    diff    = 33'(tgt_now) - 33'(alt_sel);
    if (diff[32] != diff[31]) err = diff[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                      err = diff[31:0];
    if (in_data.height_source == SRC_LIDAR) err = last_err_r;

    err_mag  = abs32(err);
    rate_mag = abs32(in_data.range_rate);
    jump     = (in_data.height_source == SRC_FLOW) &&
               (err_mag > {1'b0, cfg.error_limit}) &&
               (rate_mag > {1'b0, cfg.rate_limit});
    target_nxt = jump ? fresh : tgt_now;

    // Derivative kink: 3x slope past the knee, continuous at the knee
    c34       = 34'(in_data.climb_rate);
    climb_mag = abs32(in_data.climb_rate);
    if (climb_mag > KINK_RATE)
      vel = (c34 <<< 1) + c34 + (c34[33] ? KINK_OFFSET : -KINK_OFFSET);
    else
      vel = c34;

    q_data.setpoint = target_nxt;
    q_data.err      = err;
    q_data.vel      = vel;
    q_data.relax    = (err_mag >= ITERM_BAND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      last_err_r <= '0;
    end else if (q_wr) begin
      target_r   <= target_nxt;
      last_err_r <= err;
    end
  end

endmodule

FILE: hdl/altpid_back.sv
// ----------------------------------------------------------------------------
// altpid_back
// PID sequencer: shared multiplier, byte-serial divide by ten, output slot.
// ----------------------------------------------------------------------------
module altpid_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  altpid_pkg::altpid_cfg_t  cfg,
  input  logic                     q_empty,
  input  altpid_pkg::altpid_item_t q_data,
  output logic                     q_rd,
  output logic                     out_empty,
  input  logic                     out_pop,
  output altpid_pkg::altpid_out_t  out_data
);
  import altpid_pkg::*;

  altpid_state_t      state_r, state_nxt;
  altpid_item_t       item_r, item_nxt;
  logic signed [40:0] p_r, p_nxt;
  logic signed [42:0] d_r, d_nxt;
  logic signed [56:0] prod_r, prod_nxt;
  logic [55:0]        div_r, div_nxt;
  logic [3:0]         rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic signed [47:0] integ_r, integ_nxt;
  logic               out_valid_r, out_valid_nxt;
  altpid_out_t        out_r, out_nxt;

  logic [23:0]        mul_a;
  logic signed [33:0] mul_b;
  logic signed [58:0] mul_p;
  logic [11:0]        dx, dr;
  logic [24:0]        dq_full;
  logic [7:0]         dq;
  logic signed [56:0] ival, prod_neg;
  logic signed [48:0] isum;
  logic signed [12:0] bias_us;
  logic signed [50:0] total;
  logic               load_out;

  assign mul_p     = $signed({1'b0, mul_a}) * mul_b;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    integ_nxt     = integ_r;
    out_nxt       = out_r;
    q_rd          = 1'b0;
    load_out      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    dx       = {rem_r, div_r[55:48]};
    dq_full  = 25'(dx) * 25'(DIV10_RECIP);
    dq       = dq_full[DIV10_SHIFT +: 8];
    dr       = dx - 12'(dq) * DIV10;

    prod_neg = -prod_r;
    ival     = item_r.relax ? (neg_r ? -$signed({1'b0, div_r}) : $signed({1'b0, div_r}))
                            : prod_r;
    isum     = 49'(integ_r) + 49'($signed(ival[56:16]));

    bias_us  = $signed({1'b0, cfg.hover_throttle}) - HOVER_OFFSET;
    total    = 51'($signed({bias_us, 9'b0})) + 51'(p_r) + 51'(integ_r) - 51'(d_r);

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_rd      = 1'b1;
          item_nxt  = q_data;
          state_nxt = S_MUL_P;
        end
      end
      S_MUL_P: begin
        mul_a     = cfg.kp_gain;
        mul_b     = 34'(item_r.err);
        p_nxt     = mul_p[56:16];
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        mul_a     = cfg.ki_per_tick;
        mul_b     = 34'(item_r.err);
        prod_nxt  = mul_p[56:0];
        state_nxt = S_INT;
        if (item_r.relax) begin
          neg_nxt   = mul_p[56];
          div_nxt   = mul_p[56] ? 56'(-mul_p[56:0]) : mul_p[55:0];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_nxt = {div_r[47:0], dq};
        rem_nxt = dr[3:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 3'(DIV_STEPS - 1)) state_nxt = S_INT;
      end
      S_INT: begin
        if (isum[48] != isum[47])
          integ_nxt = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
          integ_nxt = isum[47:0];
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        mul_a     = cfg.kd_gain;
        mul_b     = item_r.vel;
        d_nxt     = mul_p[58:16];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!out_valid_r || out_pop) begin
          load_out = 1'b1;
          if (total > 51'sd2147483647)
            out_nxt.throttle_command = 32'sh7fffffff;
          else if (total < -51'sd2147483648)
            out_nxt.throttle_command = 32'sh80000000;
          else
            out_nxt.throttle_command = total[31:0];
          out_nxt.setpoint_out = item_r.setpoint;
          out_nxt.error_out    = item_r.err;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load_out)     out_valid_nxt = 1'b1;
    else if (out_pop) out_valid_nxt = 1'b0;
    else              out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    p_r    <= p_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
  end

  // prod_neg feeds only the sign check below
  a_div_only_relax: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> item_r.relax)
    else $error("divide pass without integral relax");

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (state_r == S_IDLE) && !q_empty)
    else $error("queue read outside idle");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result load lost");

  a_div_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT && item_r.relax && prod_r != '0) |->
      (neg_r == prod_r[56]) && (prod_neg[56] != prod_r[56] || prod_r[55:0] == '0))
    else $error("divide sign mismatch");

endmodule

FILE: hdl/altitude_hold_pid_top.sv
// ----------------------------------------------------------------------------
// altitude_hold_pid_top
// Altitude-hold PID with integral relax and derivative kink, queue ports.
// ----------------------------------------------------------------------------
// A tick is pushed through in_push/in_full and is accepted whenever the front
// queue has room; the front updates the setpoint and error in the cycle of
// acceptance. The back then runs the PID step on one shared 24x34 multiplier,
// with a divide pass when |error| >= 200 cm, in which the integral term is
// divided by ten one byte per cycle. Throughput is set by that back-end
// sequencer, held in its sum step by a full result slot; the result stays
// on out_data until popped while the next request is already being worked.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module altitude_hold_pid_top (
  input  logic                    clk,
  input  logic                    rst_n,
  // input request queue
  input  logic                    in_push,
  output logic                    in_full,
  input  altpid_pkg::altpid_in_t  in_data,
  // result queue
  output logic                    out_empty,
  input  logic                    out_pop,
  output altpid_pkg::altpid_out_t out_data,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_idx,
  input  logic [30:0]             cfg_wdata
);
  import altpid_pkg::*;

  altpid_cfg_t  cfg_r;
  altpid_item_t fq_wdata, fq_rdata;
  logic         fq_wr, fq_rd, fq_full, fq_empty;

  // Register file; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hover_throttle <= 12'd1500;
      cfg_r.kp_gain        <= 24'd65536;
      cfg_r.ki_per_tick    <= '0;
      cfg_r.kd_gain        <= '0;
      cfg_r.error_limit    <= 31'd12800;
      cfg_r.rate_limit     <= 31'd12800;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HOVER:     cfg_r.hover_throttle <= cfg_wdata[11:0];
        CFG_KP:        cfg_r.kp_gain        <= cfg_wdata[23:0];
        CFG_KI:        cfg_r.ki_per_tick    <= cfg_wdata[23:0];
        CFG_KD:        cfg_r.kd_gain        <= cfg_wdata[23:0];
        CFG_ERR_LIMIT: cfg_r.error_limit    <= cfg_wdata;
        CFG_RATE_LIM:  cfg_r.rate_limit     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // full mirrors the queue: a request is taken whenever there is a slot
  assign in_full = fq_full;

  // Front: setpoint/error bookkeeping and classification
  altpid_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_full  (fq_full),
    .q_wr    (fq_wr),
    .q_data  (fq_wdata)
  );

  // Decoupling queue
  altpid_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_wr),
    .wr_data (fq_wdata),
    .full    (fq_full),
    .rd_en   (fq_rd),
    .rd_data (fq_rdata),
    .empty   (fq_empty)
  );

  // Back: P, relaxed I, kinked D, bias, saturation
  altpid_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (fq_empty),
    .q_data    (fq_rdata),
    .q_rd      (fq_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
